/* rtl/core/ecw_pkg.sv */
// ----------------------------------------------------------------------------
// ecw_pkg
// Shared types and constants for the event counter with its waiter table.
// ----------------------------------------------------------------------------
package ecw_pkg;

  localparam int WAIT_SLOTS = 16;
  localparam int SLOT_W     = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
  localparam int COUNT_W    = 32;
  localparam int TASK_W     = 16;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_SUB      = 2'd1,
    CMD_REGISTER = 2'd2,
    CMD_UNUSED   = 2'd3
  } ecw_cmd_t;

  typedef enum logic [2:0] {
    KIND_RELEASED  = 3'd0,
    KIND_ADJUSTED  = 3'd1,
    KIND_QUEUED    = 3'd2,
    KIND_SATISFIED = 3'd3,
    KIND_FULL      = 3'd4
  } ecw_kind_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COUNT_W-1:0] amount;
    logic [TASK_W-1:0]  task_index;
    logic [COUNT_W-1:0] target_count;
  } ecw_in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [COUNT_W-1:0] prior_count;
    logic [COUNT_W-1:0] now_count;
    logic [TASK_W-1:0]  woken_task;
    logic               last;
  } ecw_out_t;

  typedef struct packed {
    logic [TASK_W-1:0]  task_index;
    logic [COUNT_W-1:0] target;
  } ecw_slot_t;

endpackage

/* rtl/core/ecw_slot_mem.sv */
// ----------------------------------------------------------------------------
// ecw_slot_mem
// Waiter slot storage: task index and target per slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module ecw_slot_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ecw_pkg::SLOT_W-1:0] wr_addr,
  input  ecw_pkg::ecw_slot_t        wr_data,
  input  logic                      rd_en,
  input  logic [ecw_pkg::SLOT_W-1:0] rd_addr,
  output ecw_pkg::ecw_slot_t        rd_data
);
  import ecw_pkg::*;

  ecw_slot_t mem [WAIT_SLOTS];
  ecw_slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ecw_out_reg.sv */
// ----------------------------------------------------------------------------
// ecw_out_reg
// Result output register with valid/stall handshake.
// ----------------------------------------------------------------------------
module ecw_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ecw_pkg::ecw_out_t load_item,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output ecw_pkg::ecw_out_t out_item
);
  import ecw_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  ecw_out_t item_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/core/event_counter_with_waiters_top.sv */
// ----------------------------------------------------------------------------
// event_counter_with_waiters_top
// Event counter with a waiter table. Adjust commands scan the slot memory
// and release matching waiters in slot order; register commands claim the
// lowest free slot unless the table is full or the target is already met.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   ecw_in_t  in_item
//   out      output     out_valid/out_stall ecw_out_t out_item
//
// An adjust command steps through accept, one slot memory read per slot,
// then the closing item; the slot memory has a single read port, so the
// scan reads one slot at a time.
// Reset clears the count and all occupancy bits; slot contents stay as they are.
// A stall on out holds the scan at a matching slot and blocks new input items.
// ----------------------------------------------------------------------------
module event_counter_with_waiters_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ecw_pkg::ecw_in_t in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output ecw_pkg::ecw_out_t out_item
);
  import ecw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DONE  = 3'b100
  } ecw_state_t;

  ecw_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [COUNT_W-1:0]  prior_r, prior_nxt;
  logic [WAIT_SLOTS-1:0] occ_r, occ_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  ecw_out_t            out_data;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic                wr_en;
  ecw_slot_t           wr_data;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  ecw_slot_t           rd_data;
  logic                slot_match;
  logic                last_slot;
  logic [COUNT_W-1:0]  adj_now;

  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign adj_now    = (in_item.cmd == CMD_ADD) ? count_r + in_item.amount
                                               : count_r - in_item.amount;
  assign slot_match = occ_r[idx_r] && (rd_data.target == count_r);
  assign last_slot  = (idx_r == SLOT_W'(WAIT_SLOTS - 1));
  assign wr_data    = '{task_index: in_item.task_index, target: in_item.target_count};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    prior_nxt = prior_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    out_load  = 1'b0;
    out_data  = '0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.cmd)
            CMD_ADD, CMD_SUB: begin
              count_nxt = adj_now;
              prior_nxt = count_r;
              idx_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_CHECK;
            end
            CMD_REGISTER: begin
              out_load           = 1'b1;
              out_data.now_count = count_r;
              out_data.last      = 1'b1;
              if (!free_found) begin
                out_data.kind = KIND_FULL;
              end else if (count_r == in_item.target_count) begin
                out_data.kind       = KIND_SATISFIED;
                out_data.woken_task = in_item.task_index;
              end else begin
                out_data.kind     = KIND_QUEUED;
                wr_en             = 1'b1;
                occ_nxt[free_idx] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        out_data.kind        = KIND_RELEASED;
        out_data.prior_count = prior_r;
        out_data.now_count   = count_r;
        out_data.woken_task  = rd_data.task_index;
        if (!slot_match || out_free) begin
          if (slot_match) begin
            out_load       = 1'b1;
            occ_nxt[idx_r] = 1'b0;
          end
          if (last_slot) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = idx_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        out_data.kind        = KIND_ADJUSTED;
        out_data.prior_count = prior_r;
        out_data.now_count   = count_r;
        out_data.last        = 1'b1;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prior_r <= prior_nxt;
    idx_r   <= idx_nxt;
  end

  ecw_slot_mem u_slot_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ecw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_item (out_data),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_count_held_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |=> (count_r == $past(count_r)))
    else $error("count changed during slot scan");

  a_occ_no_grow_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |=> ($countones(occ_r) <= $past($countones(occ_r))))
    else $error("slot claimed during slot scan");

  a_done_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid && out_item.last))
    else $error("closing item missing after scan");

endmodule

/* verif/ecw_checker.sv */
// ----------------------------------------------------------------------------
// ecw_checker
// Watches both channels of the event counter, keeps its own copy of the count
// and the waiter table, and compares every result item with the oldest one
// predicted. Hands the failure count and the number of outstanding results up.
// ----------------------------------------------------------------------------
module ecw_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  ecw_pkg::ecw_in_t  in_item,
  input  logic              out_valid,
  input  logic              out_stall,
  input  ecw_pkg::ecw_out_t out_item,
  output int                errors,
  output int                pending
);
  import ecw_pkg::*;

  logic [COUNT_W-1:0] count_now;
  logic               slot_busy  [WAIT_SLOTS];
  logic [TASK_W-1:0]  slot_owner [WAIT_SLOTS];
  logic [COUNT_W-1:0] slot_goal  [WAIT_SLOTS];
  ecw_out_t           due_results [$];
  int                 fail_total = 0;

  function automatic ecw_out_t make_result(ecw_kind_t k, logic [COUNT_W-1:0] prior,
                                           logic [COUNT_W-1:0] now,
                                           logic [TASK_W-1:0] task_id, logic fin);
    ecw_out_t r;
    r.kind        = k;
    r.prior_count = prior;
    r.now_count   = now;
    r.woken_task  = task_id;
    r.last        = fin;
    return r;
  endfunction

  task automatic apply_command(input ecw_in_t it);
    logic [COUNT_W-1:0] prior;
    int                 free_slot;
    case (ecw_cmd_t'(it.cmd))
      CMD_ADD, CMD_SUB: begin
        prior = count_now;
        if (it.cmd == CMD_ADD) count_now = prior + it.amount;
        else count_now = prior - it.amount;
        for (int i = 0; i < WAIT_SLOTS; i++) begin
          if (slot_busy[i] && slot_goal[i] == count_now) begin
            due_results.push_back(make_result(KIND_RELEASED, prior, count_now,
                                              slot_owner[i], 1'b0));
            slot_busy[i] = 1'b0;
          end
        end
        due_results.push_back(make_result(KIND_ADJUSTED, prior, count_now, '0, 1'b1));
      end
      CMD_REGISTER: begin
        free_slot = -1;
        for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          due_results.push_back(make_result(KIND_FULL, '0, count_now, '0, 1'b1));
        end else if (count_now == it.target_count) begin
          due_results.push_back(make_result(KIND_SATISFIED, '0, count_now,
                                            it.task_index, 1'b1));
        end else begin
          slot_busy[free_slot]  = 1'b1;
          slot_owner[free_slot] = it.task_index;
          slot_goal[free_slot]  = it.target_count;
          due_results.push_back(make_result(KIND_QUEUED, '0, count_now, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    ecw_out_t want;
    if (!rst_n) begin
      count_now = '0;
      for (int i = 0; i < WAIT_SLOTS; i++) slot_busy[i] = 1'b0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) apply_command(in_item);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %h",
                   $time, out_item);
          fail_total++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item.kind));
          check_field("prior_count", want.prior_count, out_item.prior_count);
          check_field("now_count", want.now_count, out_item.now_count);
          check_field("woken_task", 32'(want.woken_task), 32'(out_item.woken_task));
          check_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
    end
    errors  <= fail_total;
    pending <= due_results.size();
  end

endmodule

/* verif/tb_event_counter_with_waiters_top.sv */
// ----------------------------------------------------------------------------
// tb_event_counter_with_waiters_top
// Drives the event counter with a directed opening (wrap-around, a full
// table, a release of every slot at once) followed by random waiter and
// adjust sequences, with random gaps on input and random stalls on output.
// ----------------------------------------------------------------------------
module tb_event_counter_with_waiters_top;
  import ecw_pkg::*;

  localparam int GAP_MAX        = 5;
  localparam int ITEM_TARGET    = 460;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ecw_in_t            in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ecw_out_t           out_item;
  int                 errors;
  int                 pending;
  logic [COUNT_W-1:0] shadow_count = '0;
  int                 issued       = 0;
  bit                 calm_in      = 1'b0;
  bit                 calm_out     = 1'b0;
  int                 stall_left   = 0;
  int                 idle_cycles  = 0;

  event_counter_with_waiters_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  ecw_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : stall_ctl
    int draw;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      draw = calm_out ? 0 : $urandom_range(0, GAP_MAX);
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_command(input ecw_cmd_t op, input logic [COUNT_W-1:0] amount,
                               input logic [31:0] task_id,
                               input logic [COUNT_W-1:0] target);
    ecw_in_t it;
    int      gap;
    it.cmd          = op;
    it.amount       = amount;
    it.task_index   = task_id[TASK_W-1:0];
    it.target_count = target;
    gap = calm_in ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == CMD_ADD) shadow_count += amount;
    else if (op == CMD_SUB) shadow_count -= amount;
    if (op != CMD_UNUSED) issued++;
  endtask

  initial begin
    int                 choice;
    int                 k;
    int                 d;
    ecw_cmd_t           op;
    logic [COUNT_W-1:0] tgt;
    logic [COUNT_W-1:0] back;
    logic [COUNT_W-1:0] amt;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_command(CMD_REGISTER, '0, 32'hFFFF, '0);
    issue_command(CMD_SUB, 32'd1, '0, '1);
    issue_command(CMD_ADD, 32'd1, '1, '0);
    for (int i = 0; i < WAIT_SLOTS; i++) issue_command(CMD_REGISTER, $urandom, i, 32'd5);
    issue_command(CMD_REGISTER, '1, 32'h1234, '0);
    issue_command(CMD_ADD, 32'd5, '0, $urandom);
    issue_command(CMD_UNUSED, $urandom, $urandom, $urandom);
    issue_command(CMD_ADD, 32'hFFFF_FFFF, $urandom, $urandom);
    issue_command(CMD_SUB, '0, $urandom, $urandom);
    issue_command(CMD_REGISTER, '0, '0, 32'hFFFF_FFFF);
    issue_command(CMD_SUB, 32'd5, $urandom, $urandom);

    while (issued < ITEM_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 30) begin
        k   = (choice < 3) ? WAIT_SLOTS + 1 : $urandom_range(1, 4);
        d   = $urandom_range(1, 6);
        tgt = (choice % 2) ? shadow_count + d : shadow_count - d;
        for (int j = 0; j < k; j++) issue_command(CMD_REGISTER, $urandom, $urandom, tgt);
        if (choice % 2) issue_command(CMD_ADD, d, $urandom, $urandom);
        else issue_command(CMD_SUB, d, $urandom, $urandom);
      end else if (choice < 45) begin
        back = shadow_count;
        tgt  = $urandom;
        issue_command(CMD_REGISTER, $urandom, $urandom, tgt);
        if ($urandom_range(0, 1)) issue_command(CMD_ADD, tgt - shadow_count, $urandom, $urandom);
        else issue_command(CMD_SUB, shadow_count - tgt, $urandom, $urandom);
        if ($urandom_range(0, 1)) issue_command(CMD_ADD, back - shadow_count, $urandom, $urandom);
        else issue_command(CMD_SUB, shadow_count - back, $urandom, $urandom);
      end else if (choice < 55) begin
        issue_command(CMD_REGISTER, $urandom, $urandom, shadow_count);
      end else if (choice < 60) begin
        issue_command(CMD_UNUSED, $urandom, $urandom, $urandom);
      end else if (choice < 80) begin
        if ($urandom_range(0, 1)) issue_command(CMD_ADD, $urandom_range(0, 6), $urandom, $urandom);
        else issue_command(CMD_SUB, $urandom_range(0, 6), $urandom, $urandom);
      end else if (choice < 90) begin
        tgt = shadow_count + $urandom_range(0, 8) - 4;
        issue_command(CMD_REGISTER, $urandom, $urandom, tgt);
      end else begin
        op  = ecw_cmd_t'($urandom_range(0, 2));
        amt = $urandom;
        issue_command(op, amt, $urandom, $urandom);
        if (op == CMD_ADD) issue_command(CMD_SUB, amt, $urandom, $urandom);
        else if (op == CMD_SUB) issue_command(CMD_ADD, amt, $urandom, $urandom);
      end
      if ($urandom_range(0, 39) == 0) calm_in <= ~calm_in;
      if ($urandom_range(0, 39) == 0) calm_out <= ~calm_out;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (WAIT_SLOTS + 8) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ecw_pkg.sv
rtl/core/ecw_slot_mem.sv
rtl/core/ecw_out_reg.sv
rtl/core/event_counter_with_waiters_top.sv
verif/ecw_checker.sv
verif/tb_event_counter_with_waiters_top.sv
